// File: hw/rtl/time_sorted_schedule_table_core_macros.svh
// Assertion macros shared by the schedule table RTL
`ifndef TIME_SORTED_SCHEDULE_TABLE_CORE_MACROS_SVH
`define TIME_SORTED_SCHEDULE_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every edge out of reset
`define TSST_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tsst assertion failed");

// Antecedent implies consequent in the same cycle
`define TSST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsst assertion failed");

`else

`define TSST_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TSST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/tsst_pkg.sv
package tsst_pkg;

    // Field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned TM_W      = 12;
    localparam int unsigned DEV_W     = 8;
    localparam int unsigned VAL_W     = 8;
    localparam int unsigned POS_W     = 8;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned CNT_OUT_W = 5;
    localparam int unsigned ENTRY_W   = TM_W + DEV_W + VAL_W;

    // Stream word layout
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned S_TM_LSB  = 0;
    localparam int unsigned S_DEV_LSB = S_TM_LSB + TM_W;
    localparam int unsigned S_VAL_LSB = S_DEV_LSB + DEV_W;
    localparam int unsigned S_POS_LSB = S_VAL_LSB + VAL_W;
    localparam int unsigned M_USED_W  = CNT_OUT_W + TM_W + DEV_W + VAL_W;
    localparam int unsigned M_PAD_W   = M_TDATA_W - M_USED_W;

    // Time check: hours = (tm * 1311) >> 17 is exact for any 12-bit tm
    localparam int unsigned PROD_W       = 23;
    localparam int unsigned HRS_W        = 6;
    localparam int unsigned DIV100_SHIFT = 17;
    localparam logic [PROD_W-1:0] DIV100_MUL = PROD_W'(1311);
    localparam logic [TM_W-1:0]   HRS_SCALE  = TM_W'(100);
    localparam logic [HRS_W-1:0]  HOURS_MAX  = HRS_W'(23);
    localparam logic [TM_W-1:0]   MINS_MAX   = TM_W'(59);

    // Device letters and state limits
    localparam logic [DEV_W-1:0] DEV_A     = 8'h41;
    localparam logic [DEV_W-1:0] DEV_D     = 8'h44;
    localparam logic [DEV_W-1:0] DEV_E     = 8'h45;
    localparam logic [DEV_W-1:0] DEV_F     = 8'h46;
    localparam logic [VAL_W-1:0] DOOR_MAX  = VAL_W'(1);
    localparam logic [VAL_W-1:0] ANGLE_MAX = VAL_W'(180);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADPOS  = 2'd3
    } t_status;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [DEV_W-1:0] dev;
        logic [TM_W-1:0]  tm;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INS_SHIFT,
        S_DEL_SHIFT,
        S_RD_WAIT,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INS_INIT,
        IDX_POS,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_NEW
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        t_idx_op idx_op;
        t_wr_op  wr_op;
        t_cnt_op cnt_op;
        logic    res_load;
        t_status res_code;
        logic    res_take;
        logic    push;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic act_ok;
        logic full;
        logic pos_ok;
        logic ins_more;
        logic del_more;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hw/rtl/time_sorted_schedule_table_core.sv
// An insert moves each stored entry with a later time up one slot, and a delete moves each
// entry above the position down one slot; one entry moves per cycle through the table RAM.
// A read or a rejected command moves no entry.
// One command at a time: the next word is taken the cycle after the result is registered,
// so s_tready stays low from acceptance until the result is registered.
// Reset (synchronous, active low) empties the table count and control state;
// table contents are not cleared and need no clearing pass.
module time_sorted_schedule_table_core
    import tsst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // time_hhmm[11:0], device_id[19:12], device_state[27:20], position[35:28]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // entry_count[4:0], entry_time[16:5], entry_device[24:17], entry_state[32:25]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_tuser
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tsst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tsst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule

// File: hw/rtl/tsst_ram.sv
module tsst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/tsst_dp.sv
`include "time_sorted_schedule_table_core_macros.svh"

module tsst_dp
    import tsst_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [CMD_W-1:0]     i_s_tuser,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [STATUS_W-1:0]  o_m_tuser,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    // Latched command word
    t_cmd              r_cmd;
    logic [TM_W-1:0]   r_tm;
    logic [DEV_W-1:0]  r_dev;
    logic [VAL_W-1:0]  r_val;
    logic [POS_W-1:0]  r_pos;
    logic [HRS_W-1:0]  r_hrs;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;

    t_status           r_res_status;
    t_entry            r_res_entry;

    logic              r_m_valid;
    t_status           r_o_status;
    logic [CNT_OUT_W-1:0] r_o_count;
    t_entry            r_o_entry;

    logic [PROD_W-1:0] w_prod;
    logic [TM_W-1:0]   w_mins;
    logic              w_time_ok;
    logic              w_dev_ok;
    logic [CNT_W-1:0]  w_rd_idx;
    logic              w_wr_en;
    t_entry            w_wr_data;
    t_entry            w_rd_data;
    t_entry            w_new;

    // Hours by reciprocal multiply, taken at acceptance
    assign w_prod = PROD_W'(i_s_tdata[S_TM_LSB +: TM_W]) * DIV100_MUL;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= t_cmd'(i_s_tuser);
            r_tm  <= i_s_tdata[S_TM_LSB +: TM_W];
            r_dev <= i_s_tdata[S_DEV_LSB +: DEV_W];
            r_val <= i_s_tdata[S_VAL_LSB +: VAL_W];
            r_pos <= i_s_tdata[S_POS_LSB +: POS_W];
            r_hrs <= w_prod[PROD_W-1:DIV100_SHIFT];
        end
    end

    // Action check
    assign w_mins    = r_tm - (TM_W'(r_hrs) * HRS_SCALE);
    assign w_time_ok = (r_hrs <= HOURS_MAX) && (w_mins <= MINS_MAX);

    always_comb begin
        if (r_dev >= DEV_A && r_dev <= DEV_D) begin
            w_dev_ok = (r_val <= DOOR_MAX);
        end else if (r_dev >= DEV_E && r_dev <= DEV_F) begin
            w_dev_ok = (r_val <= ANGLE_MAX);
        end else begin
            w_dev_ok = 1'b0;
        end
    end

    // Walking index
    always_comb begin
        case (i_cmd.idx_op)
            IDX_HOLD:     n_idx = r_idx;
            IDX_INS_INIT: n_idx = r_count;
            IDX_POS:      n_idx = CNT_W'(r_pos) - CNT_W'(1);
            IDX_DEC:      n_idx = r_idx - CNT_W'(1);
            IDX_INC:      n_idx = r_idx + CNT_W'(1);
            default:      n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // Read one ahead of the walk: below for insert, above for delete
    always_comb begin
        case (r_cmd)
            CMD_INSERT: w_rd_idx = n_idx - CNT_W'(1);
            CMD_DELETE: w_rd_idx = n_idx + CNT_W'(1);
            default:    w_rd_idx = n_idx;
        endcase
    end

    assign w_new     = '{val: r_val, dev: r_dev, tm: r_tm};
    assign w_wr_en   = (i_cmd.wr_op != WR_NONE);
    assign w_wr_data = (i_cmd.wr_op == WR_NEW) ? w_new : w_rd_data;

    tsst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx[IDX_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Entry count
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_HOLD: n_count = r_count;
            CNT_INC:  n_count = r_count + CNT_W'(1);
            CNT_DEC:  n_count = r_count - CNT_W'(1);
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_code;
            r_res_entry  <= i_cmd.res_take ? w_rd_data : '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_status <= r_res_status;
            r_o_count  <= CNT_OUT_W'(r_count);
            r_o_entry  <= r_res_entry;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {M_PAD_W'(0), r_o_entry.val, r_o_entry.dev, r_o_entry.tm, r_o_count};
    assign o_m_tuser  = r_o_status;

    // Status to controller
    assign o_stat.cmd      = r_cmd;
    assign o_stat.act_ok   = w_time_ok && w_dev_ok;
    assign o_stat.full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_stat.pos_ok   = (r_pos != '0) && (r_pos <= POS_W'(r_count));
    assign o_stat.ins_more = (r_idx != '0) && (w_rd_data.tm > r_tm);
    assign o_stat.del_more = ((r_idx + CNT_W'(1)) < r_count);
    assign o_stat.out_free = !r_m_valid || i_m_tready;

    `TSST_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_DEPTH))
    `TSST_ASSERT_IMPL(a_wr_in_table, i_clk, i_rst_n, w_wr_en, r_idx < CNT_W'(TABLE_DEPTH))
    `TSST_ASSERT_IMPL(a_res_zero, i_clk, i_rst_n, r_m_valid && (r_o_status != ST_OK), r_o_entry == '0)

endmodule

// File: hw/rtl/tsst_ctrl.sv
`include "time_sorted_schedule_table_core_macros.svh"

module tsst_ctrl
    import tsst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: check, walk the table one entry a cycle for an insert or delete, then respond
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_stat.cmd)
                    CMD_INSERT: begin
                        if (!i_stat.act_ok) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = ST_INVALID;
                            n_state        = S_RESP;
                        end else if (i_stat.full) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = ST_FULL;
                            n_state        = S_RESP;
                        end else begin
                            o_cmd.idx_op = IDX_INS_INIT;
                            n_state      = S_INS_SHIFT;
                        end
                    end
                    CMD_DELETE: begin
                        if (!i_stat.pos_ok) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = ST_BADPOS;
                            n_state        = S_RESP;
                        end else begin
                            o_cmd.idx_op = IDX_POS;
                            n_state      = S_DEL_SHIFT;
                        end
                    end
                    CMD_READ: begin
                        if (!i_stat.pos_ok) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = ST_BADPOS;
                            n_state        = S_RESP;
                        end else begin
                            o_cmd.idx_op = IDX_POS;
                            n_state      = S_RD_WAIT;
                        end
                    end
                    default: begin
                        // unused command code
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = ST_INVALID;
                        n_state        = S_RESP;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                if (i_stat.ins_more) begin
                    o_cmd.wr_op  = WR_SHIFT;
                    o_cmd.idx_op = IDX_DEC;
                end else begin
                    o_cmd.wr_op    = WR_NEW;
                    o_cmd.cnt_op   = CNT_INC;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_OK;
                    n_state        = S_RESP;
                end
            end
            S_DEL_SHIFT: begin
                if (i_stat.del_more) begin
                    o_cmd.wr_op  = WR_SHIFT;
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    o_cmd.cnt_op   = CNT_DEC;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_OK;
                    n_state        = S_RESP;
                end
            end
            S_RD_WAIT: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = ST_OK;
                o_cmd.res_take = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `TSST_ASSERT_IMPL(a_ins_walk, i_clk, i_rst_n, r_state == S_INS_SHIFT, i_stat.cmd == CMD_INSERT)
    `TSST_ASSERT_IMPL(a_del_walk, i_clk, i_rst_n, r_state == S_DEL_SHIFT, i_stat.cmd == CMD_DELETE)
    `TSST_ASSERT_IMPL(a_push_resp, i_clk, i_rst_n, o_cmd.push, r_state == S_RESP)

endmodule
